// ----- rtl/itr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_pkg: shared types and constants for the radix text converter
// Holds the controller states, stack command struct, radix limits and the
// digit to ASCII mapping.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int VALUE_BITS = 31;   // magnitude bits of a positive input
  localparam int STEP_BITS  = 5;    // counts the VALUE_BITS division steps
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 7;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NINE  = 6'd9;
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_BITS-1:0]  CHAR_A      = 7'd65;  // 'A'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d > DIGIT_NINE) begin
      return d_ext - {1'b0, DIGIT_TEN} + CHAR_A;
    end
    return d_ext + CHAR_ZERO;
  endfunction

endpackage

// ----- rtl/integer_to_radix_text.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text: positive signed integer to ASCII digits in radix 2 to 36
// Each digit costs one pass of the bit-serial divider.
// Throughput: one input at a time, the next taken once the last beat is
//   loaded; zero or negative values skip the divider. Result stalls add delay.
// Reset (rst, synchronous) empties the pipeline and sets the radix to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_text #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: the radix register, clamped to 2..36 on write.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [itr_pkg::RADIX_BITS-1:0]  cfg_data,
  // Input channel.
  input  logic                            value_valid,
  output logic                            value_stall,
  input  logic signed [31:0]              value,
  // Result channel.
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [itr_pkg::CHAR_BITS-1:0]   digit_char,
  output logic                            no_digits,
  output logic                            last
);
  import itr_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] ONE_DIGIT = CNT_W'(1);

  state_t state, state_next;

  logic [RADIX_BITS-1:0] radix;
  logic [CNT_W-1:0]      count;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quotient;
  logic [DIGIT_BITS-1:0] div_remainder;

  stack_cmd_t            stack_cmd;
  logic [DIGIT_BITS-1:0] top_digit;

  logic                  in_beat;
  logic                  non_positive;
  logic                  out_free;
  logic                  load_digit;
  logic                  load_mark;

  // Configuration writes are always accepted; out-of-range radixes clamp.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid) begin
      if (cfg_data < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (cfg_data > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= cfg_data;
      end
    end
  end

  // A new value is taken only when the controller is idle.
  assign value_stall  = (state != ST_IDLE);
  assign in_beat      = value_valid && !value_stall;
  assign non_positive = value[31] || (value == 32'sd0);

  // The output register may be reloaded when empty or when its beat leaves.
  assign out_free = !result_valid || !result_stall;

  // The first division works on the input itself; later ones on the quotient.
  assign div_dividend = (state == ST_IDLE) ? value[VALUE_BITS-1:0] : div_quotient;

  itr_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (radix),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  itr_digit_stack #(
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk        (clk),
    .cmd        (stack_cmd),
    .push_digit (div_remainder),
    .top_digit  (top_digit)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = non_positive ? ST_MARK : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done && (div_quotient == '0)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (count == ONE_DIGIT)) begin
          state_next = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs: divider starts, stack pushes and pops, output loads.
  always_comb begin
    div_start      = 1'b0;
    stack_cmd.push = 1'b0;
    stack_cmd.pop  = 1'b0;
    load_digit     = 1'b0;
    load_mark      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        div_start = in_beat && !non_positive;
      end
      ST_DIVIDE: begin
        // Every finished division leaves one digit; continue while the
        // quotient is still nonzero.
        stack_cmd.push = div_done;
        div_start      = div_done && (div_quotient != '0);
      end
      ST_EMIT: begin
        load_digit    = out_free;
        stack_cmd.pop = out_free;
      end
      ST_MARK: begin
        load_mark = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (stack_cmd.push) begin
        count <= count + 1'b1;
      end else if (stack_cmd.pop) begin
        count <= count - 1'b1;
      end
      if (load_digit || load_mark) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload; the most significant digit sits on top of the stack.
  always_ff @(posedge clk) begin
    if (load_digit) begin
      digit_char <= digit_to_ascii(top_digit);
      no_digits  <= 1'b0;
      last       <= (count == ONE_DIGIT);
    end else if (load_mark) begin
      digit_char <= '0;
      no_digits  <= 1'b1;
      last       <= 1'b1;
    end
  end

endmodule

// ----- rtl/itr_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_divider: bit-serial restoring divider
// Divides a 31-bit magnitude by the radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itr_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [itr_pkg::VALUE_BITS-1:0]  dividend,
  input  logic [itr_pkg::RADIX_BITS-1:0]  radix,
  output logic                            done,
  output logic [itr_pkg::VALUE_BITS-1:0]  quotient,
  output logic [itr_pkg::DIGIT_BITS-1:0]  remainder
);
  import itr_pkg::*;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(VALUE_BITS - 1);

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic [DIGIT_BITS:0]   shifted;
  logic [DIGIT_BITS:0]   diff;
  logic                  fits;

  // The partial remainder stays below the radix, so one extra bit holds the shift.
  assign shifted = {remainder, quotient[VALUE_BITS-1]};
  assign fits    = shifted >= {1'b0, radix};
  assign diff    = shifted - {1'b0, radix};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[VALUE_BITS-2:0], fits};
      remainder <= fits ? diff[DIGIT_BITS-1:0] : shifted[DIGIT_BITS-1:0];
    end
  end

endmodule

// ----- rtl/itr_digit_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_digit_stack: shift-register digit stack
// Remainders shift in at the head; the most recent digit is popped first.
// ----------------------------------------------------------------------------
module itr_digit_stack #(
  parameter int DEPTH = 32
) (
  input  logic                            clk,
  input  itr_pkg::stack_cmd_t             cmd,
  input  logic [itr_pkg::DIGIT_BITS-1:0]  push_digit,
  output logic [itr_pkg::DIGIT_BITS-1:0]  top_digit
);
  import itr_pkg::*;

  logic [DIGIT_BITS-1:0] slots [DEPTH];

  assign top_digit = slots[0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      slots[0] <= push_digit;
      for (int i = 1; i < DEPTH; i++) begin
        slots[i] <= slots[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

endmodule
